@@ rtl/core/fma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame MSE accumulator package
// Widths, register indexes, queue record and divider request/response types,
// and the back-end state encoding shared by the frame_mse_accumulator files.
// ----------------------------------------------------------------------------
package fma_pkg;

    localparam int SIDE_W      = 13;
    localparam int AREA_W      = 2 * SIDE_W;
    localparam int FSUM_W      = 40;
    localparam int TSUM_W      = 56;
    localparam int COUNT_W     = 16;
    localparam int ERR_W       = 24;
    localparam int DEN_W       = AREA_W + COUNT_W;
    localparam int MAX_SIDE    = 4096;
    localparam int QUEUE_DEPTH = 2;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [SIDE_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [SIDE_W-1:0] RESET_HEIGHT = 13'd480;

    // Register index taken from paddr[2].
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // One closed frame, handed from the front end to the back end.
    typedef struct packed {
        logic [FSUM_W-1:0] sum;
        logic [AREA_W-1:0] area;
        logic              final_frame;
    } fma_rec_t;

    typedef struct packed {
        logic              start;
        logic [TSUM_W-1:0] num;
        logic [DEN_W-1:0]  den;
    } fma_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ERR_W-1:0] quot;
    } fma_div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_FRAME,
        ST_MULT,
        ST_TOTAL_START,
        ST_DIV_TOTAL,
        ST_OUT
    } fma_state_t;

endpackage

@@ rtl/core/fma_pixel_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel pair channel
// Valid/ready channel carrying one pair of co-located pixels per item.
// ----------------------------------------------------------------------------
interface fma_pixel_if #(
    parameter int PIXEL_BITS = 8
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_a;
    logic [PIXEL_BITS-1:0] pixel_b;
    logic                  final_frame;

    modport source (output valid, output pixel_a, output pixel_b, output final_frame,
                    input ready);
    modport sink   (input valid, input pixel_a, input pixel_b, input final_frame,
                    output ready);
endinterface

@@ rtl/core/fma_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel carrying one frame error report per item.
// ----------------------------------------------------------------------------
interface fma_result_if ();
    logic                        valid;
    logic                        ready;
    logic [fma_pkg::COUNT_W-1:0] frame_number;
    logic [fma_pkg::ERR_W-1:0]   frame_mse;
    logic [fma_pkg::ERR_W-1:0]   max_mse;
    logic [fma_pkg::ERR_W-1:0]   mean_mse;
    logic                        sequence_done;

    modport source (output valid, output frame_number, output frame_mse, output max_mse,
                    output mean_mse, output sequence_done, input ready);
    modport sink   (input valid, input frame_number, input frame_mse, input max_mse,
                    input mean_mse, input sequence_done, output ready);
endinterface

@@ rtl/core/fma_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame MSE front end
// Squares pixel differences, accumulates the frame sum and detects frame end.
// ----------------------------------------------------------------------------
module fma_front #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fma_pixel_if.sink                   pix,
    input  logic [fma_pkg::AREA_W-1:0]  area,
    input  logic                        queue_full,
    output logic                        push,
    output fma_pkg::fma_rec_t           push_rec
);
    localparam int SQ_W      = 2 * PIXEL_BITS;
    localparam int FSUM_W    = fma_pkg::FSUM_W;
    localparam int SUM_EXT_W = FSUM_W + 1;
    localparam int AREA_W    = fma_pkg::AREA_W;

    logic                  s0_valid_reg;
    logic [SQ_W-1:0]       s0_sq_reg;
    logic                  s0_final_reg;
    logic [FSUM_W-1:0]     frame_sum_reg;
    logic [AREA_W-1:0]     pixel_count_reg;

    logic [PIXEL_BITS-1:0] diff;
    logic [SQ_W-1:0]       sq_next;
    logic [SUM_EXT_W-1:0]  sum_ext;
    logic [FSUM_W-1:0]     sum_sat;
    logic [AREA_W-1:0]     count_inc;
    logic                  close;
    logic                  stall;

    assign diff    = (pix.pixel_a >= pix.pixel_b) ? (pix.pixel_a - pix.pixel_b)
                                                  : (pix.pixel_b - pix.pixel_a);
    assign sq_next = SQ_W'(diff) * SQ_W'(diff);

    assign sum_ext   = {1'b0, frame_sum_reg} + SUM_EXT_W'(s0_sq_reg);
    assign sum_sat   = sum_ext[FSUM_W] ? {FSUM_W{1'b1}} : sum_ext[FSUM_W-1:0];
    assign count_inc = pixel_count_reg + AREA_W'(1);
    assign close     = count_inc >= area;

    // The whole front end holds when a frame closes and the queue has no room.
    assign stall     = s0_valid_reg && close && queue_full;
    assign pix.ready = !stall;
    assign push      = s0_valid_reg && close && !queue_full;

    assign push_rec.sum         = sum_sat;
    assign push_rec.area        = area;
    assign push_rec.final_frame = s0_final_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg    <= 1'b0;
            frame_sum_reg   <= '0;
            pixel_count_reg <= '0;
        end
        else if (!stall)
        begin
            s0_valid_reg <= pix.valid;
            if (s0_valid_reg)
            begin
                if (close)
                begin
                    frame_sum_reg   <= '0;
                    pixel_count_reg <= '0;
                end
                else
                begin
                    frame_sum_reg   <= sum_sat;
                    pixel_count_reg <= count_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s0_sq_reg    <= sq_next;
            s0_final_reg <= pix.final_frame;
        end
    end

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (pixel_count_reg == '0) && (frame_sum_reg == '0))
        else $error("frame state not cleared after frame close");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> s0_valid_reg && $stable(s0_sq_reg) && $stable(pixel_count_reg))
        else $error("front stage moved while stalled");

endmodule

@@ rtl/core/fma_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame record queue
// Small register queue of closed-frame records between front and back end.
// ----------------------------------------------------------------------------
module fma_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fma_pkg::fma_rec_t wr_rec,
    input  logic              pop,
    output fma_pkg::fma_rec_t rd_rec,
    output logic              full,
    output logic              empty
);
    localparam int DEPTH = fma_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fma_pkg::fma_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full   = count_reg == CNT_W'(DEPTH);
    assign empty  = count_reg == '0;
    assign rd_rec = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_rec;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("frame record pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("frame record popped from an empty queue");

endmodule

@@ rtl/core/fma_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring radix-2 divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module fma_div #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fma_pkg::fma_div_req_t req,
    output fma_pkg::fma_div_rsp_t rsp
);
    localparam int TSUM_W = fma_pkg::TSUM_W;
    localparam int DEN_W  = fma_pkg::DEN_W;
    localparam int ERR_W  = fma_pkg::ERR_W;
    localparam int NUM_W  = TSUM_W + FRACTION_BITS;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int REM_W  = DEN_W + 1;

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [ERR_W-1:0] quot_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] step_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] rem_sub;
    logic             take;

    // The remainder stays below the divisor, so one extra bit holds the shift.
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign take      = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = ovf_reg ? {ERR_W{1'b1}} : quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= NUM_W'(req.num) << FRACTION_BITS;
            den_reg  <= req.den;
            rem_reg  <= '0;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_reg << 1;
            rem_reg  <= take ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            // A one shifted out of the top of the quotient means saturation.
            ovf_reg  <= ovf_reg | quot_reg[ERR_W-1];
            quot_reg <= {quot_reg[ERR_W-2:0], take};
        end
    end

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a running division");

endmodule

@@ rtl/core/fma_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame MSE back end
// Sequences the per-frame work: sequence totals, frame and sequence means.
// ----------------------------------------------------------------------------
module fma_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fma_pkg::fma_rec_t     rd_rec,
    input  logic                  queue_empty,
    output logic                  pop,
    output fma_pkg::fma_div_req_t div_req,
    input  fma_pkg::fma_div_rsp_t div_rsp,
    fma_result_if.source          res
);
    localparam int TSUM_W    = fma_pkg::TSUM_W;
    localparam int TSUM_EX_W = TSUM_W + 1;
    localparam int COUNT_W   = fma_pkg::COUNT_W;
    localparam int ERR_W     = fma_pkg::ERR_W;
    localparam int DEN_W     = fma_pkg::DEN_W;

    fma_pkg::fma_state_t state_reg, state_next;
    fma_pkg::fma_rec_t   rec_reg, rec_next;
    logic [TSUM_W-1:0]   total_reg, total_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [ERR_W-1:0]    largest_reg, largest_next;
    logic [COUNT_W-1:0]  index_reg, index_next;
    logic [ERR_W-1:0]    err_reg, err_next;
    logic [ERR_W-1:0]    mean_reg, mean_next;
    logic [DEN_W-1:0]    den_reg, den_next;

    logic [TSUM_EX_W-1:0] total_ext;

    assign total_ext = {1'b0, total_reg} + TSUM_EX_W'(rec_reg.sum);

    assign res.valid         = state_reg == fma_pkg::ST_OUT;
    assign res.frame_number  = index_reg;
    assign res.frame_mse     = err_reg;
    assign res.max_mse       = largest_reg;
    assign res.mean_mse      = mean_reg;
    assign res.sequence_done = rec_reg.final_frame;

    always_comb
    begin
        state_next   = state_reg;
        rec_next     = rec_reg;
        total_next   = total_reg;
        count_next   = count_reg;
        largest_next = largest_reg;
        index_next   = index_reg;
        err_next     = err_reg;
        mean_next    = mean_reg;
        den_next     = den_reg;
        pop          = 1'b0;
        div_req      = '0;

        case (state_reg)
            fma_pkg::ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    rec_next   = rd_rec;
                    state_next = fma_pkg::ST_UPDATE;
                end
            end
            fma_pkg::ST_UPDATE:
            begin
                total_next = total_ext[TSUM_W] ? {TSUM_W{1'b1}} : total_ext[TSUM_W-1:0];
                index_next = count_reg;
                if (count_reg != {COUNT_W{1'b1}})
                    count_next = count_reg + COUNT_W'(1);
                div_req.start = 1'b1;
                div_req.num   = TSUM_W'(rec_reg.sum);
                div_req.den   = DEN_W'(rec_reg.area);
                state_next    = fma_pkg::ST_DIV_FRAME;
            end
            fma_pkg::ST_DIV_FRAME:
            begin
                if (div_rsp.done)
                begin
                    err_next = div_rsp.quot;
                    if (div_rsp.quot > largest_reg)
                        largest_next = div_rsp.quot;
                    if (rec_reg.final_frame)
                        state_next = fma_pkg::ST_MULT;
                    else
                    begin
                        mean_next  = '0;
                        state_next = fma_pkg::ST_OUT;
                    end
                end
            end
            fma_pkg::ST_MULT:
            begin
                den_next   = DEN_W'(rec_reg.area) * DEN_W'(count_reg);
                state_next = fma_pkg::ST_TOTAL_START;
            end
            fma_pkg::ST_TOTAL_START:
            begin
                div_req.start = 1'b1;
                div_req.num   = total_reg;
                div_req.den   = den_reg;
                state_next    = fma_pkg::ST_DIV_TOTAL;
            end
            fma_pkg::ST_DIV_TOTAL:
            begin
                if (div_rsp.done)
                begin
                    mean_next  = div_rsp.quot;
                    state_next = fma_pkg::ST_OUT;
                end
            end
            fma_pkg::ST_OUT:
            begin
                if (res.ready)
                begin
                    if (rec_reg.final_frame)
                    begin
                        total_next   = '0;
                        count_next   = '0;
                        largest_next = '0;
                    end
                    state_next = fma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fma_pkg::ST_IDLE;
            total_reg   <= '0;
            count_reg   <= '0;
            largest_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            count_reg   <= count_next;
            largest_reg <= largest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg   <= rec_next;
        index_reg <= index_next;
        err_reg   <= err_next;
        mean_reg  <= mean_next;
        den_reg   <= den_next;
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> res.valid && $stable(err_reg) && $stable(mean_reg))
        else $error("frame result changed while waiting");

    a_mean_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !rec_reg.final_frame) |-> (mean_reg == '0))
        else $error("sequence mean given outside the final frame");

endmodule

@@ rtl/core/frame_mse_accumulator.sv @@
// A frame result appears once the frame's last item has passed the square register, the
// queue and one division in the back end (two on the final frame). Throughput: one
// pixel item per cycle, but the front end stalls when a frame closes with the queue
// full; each close holds the back end for one serial division (two on the final frame),
// which a queue of closed frames absorbs. Reset is asynchronous and active low; it
// clears all accumulators and the queue, sets a 640 by 480 frame; no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame MSE accumulator
// Mean squared error between two video sequences, per frame and per sequence.
// ----------------------------------------------------------------------------
module frame_mse_accumulator #(
    parameter int PIXEL_BITS    = 8,
    parameter int FRACTION_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // APB-style configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fma_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fma_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fma_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    // Pixel pair items in, frame results out.
    fma_pixel_if.sink                        pix,
    fma_result_if.source                     res
);
    localparam int SIDE_W = fma_pkg::SIDE_W;
    localparam int AREA_W = fma_pkg::AREA_W;
    localparam int DATA_W = fma_pkg::APB_DATA_W;

    // Configuration registers. The register index is paddr[2]; the low
    // address bits are not decoded.
    logic [SIDE_W-1:0] width_reg;
    logic [SIDE_W-1:0] height_reg;
    logic              cfg_write;
    logic              cfg_index;

    logic [SIDE_W-1:0] width_eff;
    logic [SIDE_W-1:0] height_eff;
    logic [AREA_W-1:0] area;

    logic                  push;
    fma_pkg::fma_rec_t     push_rec;
    logic                  pop;
    fma_pkg::fma_rec_t     rd_rec;
    logic                  queue_full;
    logic                  queue_empty;
    fma_pkg::fma_div_req_t div_req;
    fma_pkg::fma_div_rsp_t div_rsp;

    assign pready    = 1'b1;
    assign cfg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_index)
            fma_pkg::REG_FRAME_WIDTH:  prdata = DATA_W'(width_reg);
            fma_pkg::REG_FRAME_HEIGHT: prdata = DATA_W'(height_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fma_pkg::RESET_WIDTH;
            height_reg <= fma_pkg::RESET_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fma_pkg::REG_FRAME_WIDTH:  width_reg  <= pwdata[SIDE_W-1:0];
                fma_pkg::REG_FRAME_HEIGHT: height_reg <= pwdata[SIDE_W-1:0];
                default:                   width_reg  <= width_reg;
            endcase
        end
    end

    // A side of zero counts as one, and a side beyond the largest supported
    // frame counts as that largest side.
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0)
            r = SIDE_W'(1);
        else if (v > SIDE_W'(fma_pkg::MAX_SIDE))
            r = SIDE_W'(fma_pkg::MAX_SIDE);
        else
            r = v;
        return r;
    endfunction

    assign width_eff  = clamp_side(width_reg);
    assign height_eff = clamp_side(height_reg);
    assign area       = AREA_W'(width_eff) * AREA_W'(height_eff);

    // Front end: squares each difference, sums the frame and spots its end.
    fma_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .area       (area),
        .queue_full (queue_full),
        .push       (push),
        .push_rec   (push_rec)
    );

    // Closed frames wait here while the back end divides.
    fma_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_rec (push_rec),
        .pop    (pop),
        .rd_rec (rd_rec),
        .full   (queue_full),
        .empty  (queue_empty)
    );

    // One serial divider serves both the frame mean and the sequence mean.
    fma_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Back end: sequence totals, largest error and the result register.
    fma_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_rec      (rd_rec),
        .queue_empty (queue_empty),
        .pop         (pop),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .res         (res)
    );

    a_area_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        area != '0)
        else $error("frame area is zero");

    a_result_from_back: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !div_rsp.busy)
        else $error("result shown while a division runs");

    a_push_sees_area: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_rec.area == area))
        else $error("closed frame carries a stale area");

endmodule
